// ===== rtl/core/olpef_pkg.sv =====
// Shared types and constants for the one-pole low-pass filter with remainder feedback.
// No dependencies.
package olpef_pkg;

  localparam int NUM_FILTERS_DEF = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int IDX_IN_W   = 4;
  localparam int NUM_W      = 16;
  localparam int DEN_W      = 24;
  localparam int REM_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_DEN = 2'd1;

  localparam logic [NUM_W-1:0] NUM_RESET = 16'd1;
  localparam logic [DEN_W-1:0] DEN_RESET = 24'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIN
  } olpef_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } serial_stat_t;

endpackage

// ===== rtl/core/olpef_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module olpef_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/olpef_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle, accumulator preloaded.
// Depends on olpef_pkg.
module olpef_mul
  import olpef_pkg::*;
#(
  parameter int AccW = 50,
  parameter int MplW = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [AccW-1:0] mcand,
  input  logic [MplW-1:0] mplier,
  input  logic [AccW-1:0] init,
  output serial_stat_t    stat,
  output logic [AccW-1:0] product
);

  localparam int CNT_W = $clog2(MplW + 1);

  logic [AccW-1:0]  acc_r;
  logic [AccW-1:0]  mcand_r;
  logic [MplW-1:0]  mplier_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == CNT_W'(1));
  assign product   = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(MplW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= init;
      mcand_r  <= mcand;
      mplier_r <= mplier;
    end else if (busy_r) begin
      acc_r    <= acc_r + (mplier_r[0] ? mcand_r : '0);
      mcand_r  <= {mcand_r[AccW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[MplW-1:1]};
    end
  end

endmodule

// ===== rtl/core/olpef_div.sv =====
// Restoring radix-2 divider: one quotient bit per cycle, quotient shifts into the dividend.
// Depends on olpef_pkg.
module olpef_div
  import olpef_pkg::*;
#(
  parameter int DvdW = 50,
  parameter int DvsW = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  input  logic [DvsW-1:0] divisor,
  output serial_stat_t    stat,
  output logic [DvdW-1:0] quotient,
  output logic [DvsW-1:0] remainder
);

  localparam int CNT_W = $clog2(DvdW + 1);

  logic [DvdW-1:0]  quo_r;
  logic [DvsW-1:0]  rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DvsW:0]    rem_sh;
  logic             ge;

  assign rem_sh    = {rem_r, quo_r[DvdW-1]};
  assign ge        = rem_sh >= {1'b0, divisor};
  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == CNT_W'(1));
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DvdW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DvdW-2:0], ge};
      rem_r <= ge ? DvsW'(rem_sh - {1'b0, divisor}) : rem_sh[DvsW-1:0];
    end
  end

endmodule

// ===== rtl/core/one_pole_lowpass_error_feedback.sv =====
// Flow: an accepted sample passes ST_LOAD, the serial multiply (ST_MUL), ST_ABS, the
//   serial divide (ST_DIV) and ST_FIN, with accumulator width ACC_W = min(SampleBits + 18, 64).
// A new sample is taken only in ST_IDLE, once the last one is through; ST_FIN waits
//   while out_valid is held unread, else the output register frees the input side.
// Reset (rst_n low, synchronous): control idle, alpha = 1/1024, all filter state
//   reads as zero through per-entry valid bits; no clearing pass.
module one_pole_lowpass_error_feedback
  import olpef_pkg::*;
#(
  parameter int NumFilters = NUM_FILTERS_DEF,
  parameter int SampleBits = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [IDX_IN_W-1:0]        in_filter_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_filtered,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W  = (NumFilters > 1) ? $clog2(NumFilters) : 1;
  localparam int ACC_W  = (SampleBits + 18 > 64) ? 64 : SampleBits + 18;
  localparam int DIFF_W = SampleBits + 1;
  localparam int SUM_W  = SampleBits + 3;
  localparam int RAM_W  = SampleBits + REM_W;
  localparam logic [SampleBits-1:0] HI = {1'b0, {(SampleBits - 1){1'b1}}};
  localparam logic [SampleBits-1:0] LO = {1'b1, {(SampleBits - 1){1'b0}}};

  function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_IN_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << IDX_IN_W); k++) begin
      if (v == IDX_IN_W'(k)) begin
        r = IDX_W'(k % NumFilters);
      end
    end
    return r;
  endfunction

  olpef_state_t state_r, state_nxt;

  logic [NUM_W-1:0]             alpha_num_r;
  logic [DEN_W-1:0]             alpha_den_r;
  logic [DEN_W-1:0]             den_eff;
  logic [NumFilters-1:0]        valid_r;
  logic                         vld_rd_r;
  logic [IDX_W-1:0]             idx_r;
  logic [IDX_W-1:0]             raddr;
  logic signed [SampleBits-1:0] sample_r;
  logic                         neg_r;
  logic                         out_valid_r;
  logic signed [SAMPLE_W-1:0]   out_filtered_r;

  logic [RAM_W-1:0]             ram_rdata;
  logic [RAM_W-1:0]             ram_wdata;
  logic                         ram_we;

  logic signed [SampleBits-1:0] prev_s;
  logic signed [REM_W-1:0]      rem_old_s;
  logic signed [DIFF_W-1:0]     diff_s;

  logic                         mul_start;
  serial_stat_t                 mul_stat;
  logic [ACC_W-1:0]             mul_prod;
  logic [ACC_W-1:0]             mag;

  logic                         div_start;
  serial_stat_t                 div_stat;
  logic [ACC_W-1:0]             div_quo;
  logic [DEN_W-1:0]             div_rem;

  logic                         q_over;
  logic [SUM_W-1:0]             q_mag;
  logic [SUM_W-1:0]             q_sgn;
  logic [SUM_W-1:0]             sum;
  logic                         in_range;
  logic signed [SampleBits-1:0] result_s;
  logic [REM_W-1:0]             rem_new;
  logic                         fin_fire;
  logic                         in_xfer;

  assign in_ready     = (state_r == ST_IDLE);
  assign in_xfer      = in_valid && in_ready;
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign den_eff      = (alpha_den_r == '0) ? DEN_W'(1) : alpha_den_r;
  assign raddr        = in_ready ? idx_wrap(in_filter_index) : idx_r;

  // stored state, zero until first write of the entry
  assign prev_s    = vld_rd_r ? ram_rdata[RAM_W-1:REM_W] : '0;
  assign rem_old_s = vld_rd_r ? ram_rdata[REM_W-1:0] : '0;
  assign diff_s    = DIFF_W'(sample_r) - DIFF_W'(prev_s);

  assign mag = mul_prod[ACC_W-1] ? (~mul_prod + ACC_W'(1)) : mul_prod;

  // quotient magnitude above 2^SampleBits saturates directly
  assign q_over   = (|div_quo[ACC_W-1:SampleBits+1]) ||
                    (div_quo[SampleBits] && (|div_quo[SampleBits-1:0]));
  assign q_mag    = SUM_W'(div_quo[SampleBits:0]);
  assign q_sgn    = neg_r ? (~q_mag + SUM_W'(1)) : q_mag;
  assign sum      = SUM_W'(prev_s) + q_sgn;
  assign in_range = (&sum[SUM_W-1:SampleBits-1]) || !(|sum[SUM_W-1:SampleBits-1]);

  always_comb begin
    if (q_over) begin
      result_s = neg_r ? LO : HI;
    end else if (in_range) begin
      result_s = sum[SampleBits-1:0];
    end else begin
      result_s = sum[SUM_W-1] ? LO : HI;
    end
  end

  assign rem_new   = neg_r ? (~{1'b0, div_rem} + REM_W'(1)) : {1'b0, div_rem};
  assign ram_wdata = {result_s, rem_new};
  assign ram_we    = fin_fire;

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    fin_fire  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_nxt = ST_ABS;
        end
      end
      ST_ABS: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          fin_fire  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alpha_num_r <= NUM_RESET;
      alpha_den_r <= DEN_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA_NUM: alpha_num_r <= cfg_data[NUM_W-1:0];
          CFG_ALPHA_DEN: alpha_den_r <= cfg_data[DEN_W-1:0];
          default: ;
        endcase
      end
      if (fin_fire) begin
        valid_r[idx_r] <= 1'b1;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_rd_r <= valid_r[raddr];
    if (in_xfer) begin
      idx_r    <= idx_wrap(in_filter_index);
      sample_r <= SampleBits'(in_sample);
    end
    if (state_r == ST_ABS) begin
      neg_r <= mul_prod[ACC_W-1];
    end
    if (fin_fire) begin
      out_filtered_r <= SAMPLE_W'(result_s);
    end
  end

  olpef_ram #(
    .Width(RAM_W),
    .Depth(NumFilters)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  olpef_mul #(
    .AccW(ACC_W),
    .MplW(NUM_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (ACC_W'(diff_s)),
    .mplier (alpha_num_r),
    .init   (ACC_W'(rem_old_s)),
    .stat   (mul_stat),
    .product(mul_prod)
  );

  olpef_div #(
    .DvdW(ACC_W),
    .DvsW(DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (den_eff),
    .stat     (div_stat),
    .quotient (div_quo),
    .remainder(div_rem)
  );

`ifndef SYNTHESIS
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> mul_stat.busy)
    else $error("multiplier idle during multiply phase");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> div_stat.busy)
    else $error("divider idle during divide phase");

  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!mul_stat.busy && !div_stat.busy))
    else $error("serial unit busy while accepting input");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (div_rem < den_eff))
    else $error("remainder not below divisor");
`endif

endmodule
